// ===== sv/bdc_pkg.sv =====
package bdc_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 22;
   localparam int STAT_W  = 2;
   localparam int DNUM_W  = 22;
   localparam int Q100_W  = 8;
   localparam int Q7_W    = 20;

   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_ORDER   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd2;

   localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
   localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd2;
   localparam logic [MONTH_W-1:0] DECEMBER  = 4'd12;

   // x / 100 = (x * 5243) >> 19, exact for x below 16384
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int          DIV100_SHIFT = 19;
   // x / 7 = (x * 4793491) >> 25, exact for x below 2^22
   localparam logic [22:0] DIV7_MUL     = 23'd4793491;
   localparam int          DIV7_SHIFT   = 25;

   // day 0 (1 Mar of year 0) falls on a wednesday
   localparam logic [2:0] EPOCH_WEEKDAY = 3'd3;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_YEAR,
      OP_CHECK,
      OP_DNUM,
      OP_DIFF,
      OP_DIV_W,
      OP_REM_W,
      OP_DIV_T,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
      logic   sel_end;
   } cmd_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd2:    len = 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // days from 1 Mar to the first of month m, march-based year
   function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [8:0] off;
      case (m)
         4'd3:    off = 9'd0;
         4'd4:    off = 9'd31;
         4'd5:    off = 9'd61;
         4'd6:    off = 9'd92;
         4'd7:    off = 9'd122;
         4'd8:    off = 9'd153;
         4'd9:    off = 9'd184;
         4'd10:   off = 9'd214;
         4'd11:   off = 9'd245;
         4'd12:   off = 9'd275;
         4'd1:    off = 9'd306;
         4'd2:    off = 9'd337;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

   // weekdays among the r days that start on weekday w
   function automatic logic [2:0] partial_week(input logic [2:0] w, input logic [2:0] r);
      logic [2:0] n;
      logic [3:0] d;
      n = 3'd0;
      for (int i = 0; i < 7; i++) begin
         d = 4'(w) + 4'(i);
         if (d >= 4'd7) begin
            d = d - 4'd7;
         end
         if (3'(i) < r && d != 4'd0 && d != 4'd6) begin
            n = n + 3'd1;
         end
      end
      return n;
   endfunction

endpackage

// ===== sv/bdc_req_if.sv =====
interface bdc_req_if
   import bdc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [DAY_W-1:0]   start_day;
   logic [MONTH_W-1:0] start_month;
   logic [YEAR_W-1:0]  start_year;
   logic [DAY_W-1:0]   end_day;
   logic [MONTH_W-1:0] end_month;
   logic [YEAR_W-1:0]  end_year;

   modport source (
      output valid, start_day, start_month, start_year, end_day, end_month, end_year,
      input  ready
   );
   modport sink (
      input  valid, start_day, start_month, start_year, end_day, end_month, end_year,
      output ready
   );
endinterface

// ===== sv/bdc_rsp_if.sv =====
interface bdc_rsp_if
   import bdc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] business_days;
   logic [STAT_W-1:0]  status;

   modport source (
      output valid, business_days, status,
      input  ready
   );
   modport sink (
      input  valid, business_days, status,
      output ready
   );
endinterface

// ===== sv/bdc_ctrl.sv =====
module bdc_ctrl
   import bdc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_S_YEAR,
      ST_S_CHECK,
      ST_S_DNUM,
      ST_E_YEAR,
      ST_E_CHECK,
      ST_E_DNUM,
      ST_DIFF,
      ST_DIV_W,
      ST_REM_W,
      ST_DIV_T,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_IDLE;
      cmd.sel_end  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_S_YEAR;
            end
         end
         ST_S_YEAR: begin
            cmd.op   = OP_YEAR;
            state_in = ST_S_CHECK;
         end
         ST_S_CHECK: begin
            cmd.op   = OP_CHECK;
            state_in = ST_S_DNUM;
         end
         ST_S_DNUM: begin
            cmd.op   = OP_DNUM;
            state_in = ST_E_YEAR;
         end
         ST_E_YEAR: begin
            cmd.op      = OP_YEAR;
            cmd.sel_end = 1'b1;
            state_in    = ST_E_CHECK;
         end
         ST_E_CHECK: begin
            cmd.op      = OP_CHECK;
            cmd.sel_end = 1'b1;
            state_in    = ST_E_DNUM;
         end
         ST_E_DNUM: begin
            cmd.op      = OP_DNUM;
            cmd.sel_end = 1'b1;
            state_in    = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_DIV_W;
         end
         ST_DIV_W: begin
            cmd.op   = OP_DIV_W;
            state_in = ST_REM_W;
         end
         ST_REM_W: begin
            cmd.op   = OP_REM_W;
            state_in = ST_DIV_T;
         end
         ST_DIV_T: begin
            cmd.op   = OP_DIV_T;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // wait here while the previous word is still unclaimed
            if (slot_free) begin
               cmd.op       = OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/bdc_datapath.sv =====
module bdc_datapath
   import bdc_pkg::*;
(
   input  logic               clock,
   input  cmd_type            cmd,
   input  logic [DAY_W-1:0]   start_day,
   input  logic [MONTH_W-1:0] start_month,
   input  logic [YEAR_W-1:0]  start_year,
   input  logic [DAY_W-1:0]   end_day,
   input  logic [MONTH_W-1:0] end_month,
   input  logic [YEAR_W-1:0]  end_year,
   output logic [COUNT_W-1:0] business_days,
   output logic [STAT_W-1:0]  status
);

   logic [DAY_W-1:0]   sd_ff, ed_ff;
   logic [MONTH_W-1:0] sm_ff, em_ff;
   logic [YEAR_W-1:0]  sy_ff, ey_ff;
   logic [YEAR_W-1:0]  yy_ff, yy_in;
   logic [Q100_W-1:0]  qy_ff, qyy_ff;
   logic               ok_s_ff, ok_e_ff;
   logic [DNUM_W-1:0]  ns_ff, ne_ff, total_ff;
   logic [Q7_W-1:0]    q7_ff;
   logic [2:0]         w_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [STAT_W-1:0]  status_ff;

   logic [DAY_W-1:0]   d_sel;
   logic [MONTH_W-1:0] m_sel;
   logic [YEAR_W-1:0]  y_sel;
   logic [YEAR_W-1:0]  arg100;
   logic [26:0]        prod100;
   logic [Q100_W-1:0]  q100;
   logic [DNUM_W-1:0]  ns3;
   logic [DNUM_W-1:0]  arg7;
   logic [44:0]        prod7;
   logic [Q7_W-1:0]    q7;
   logic [DNUM_W-1:0]  q7_times7;
   logic               leap;
   logic [DAY_W-1:0]   len;
   logic               date_ok;
   logic [DNUM_W-1:0]  dnum;
   logic [2:0]         rem_t;
   logic [COUNT_W-1:0] count_val;

   assign d_sel = cmd.sel_end ? ed_ff : sd_ff;
   assign m_sel = cmd.sel_end ? em_ff : sm_ff;
   assign y_sel = cmd.sel_end ? ey_ff : sy_ff;

   // january and february belong to the previous march-based year
   assign yy_in = (m_sel <= FEBRUARY) ? (y_sel - YEAR_W'(1)) : y_sel;

   // shared divide by 100
   assign arg100  = (cmd.op == OP_YEAR) ? y_sel : yy_ff;
   assign prod100 = 27'(arg100) * 27'(DIV100_MUL);
   assign q100    = Q100_W'(prod100 >> DIV100_SHIFT);

   // shared divide by 7
   assign ns3       = ns_ff + DNUM_W'(EPOCH_WEEKDAY);
   assign arg7      = (cmd.op == OP_DIV_T) ? total_ff : ns3;
   assign prod7     = 45'(arg7) * 45'(DIV7_MUL);
   assign q7        = Q7_W'(prod7 >> DIV7_SHIFT);
   assign q7_times7 = DNUM_W'(q7_ff) * DNUM_W'(7);

   assign leap = (y_sel[1:0] == 2'd0) &&
                 ((15'(y_sel) != 15'(qy_ff) * 15'd100) || (qy_ff[1:0] == 2'd0));
   assign len  = (m_sel == FEBRUARY && leap) ? 5'd29 : month_len(m_sel);
   assign date_ok = (y_sel != '0) && (y_sel <= MAX_YEAR) &&
                    (m_sel != '0) && (m_sel <= DECEMBER) &&
                    (d_sel != '0) && (d_sel <= len);

   assign dnum = DNUM_W'(yy_ff) * DNUM_W'(365) + DNUM_W'(yy_ff >> 2)
               - DNUM_W'(qyy_ff) + DNUM_W'(qyy_ff >> 2)
               + DNUM_W'(month_offset(m_sel)) + DNUM_W'(d_sel) - DNUM_W'(1);

   assign rem_t     = 3'(total_ff - q7_times7);
   assign count_val = COUNT_W'(q7_ff) * COUNT_W'(5) + COUNT_W'(partial_week(w_ff, rem_t));

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            sd_ff <= start_day;
            sm_ff <= start_month;
            sy_ff <= start_year;
            ed_ff <= end_day;
            em_ff <= end_month;
            ey_ff <= end_year;
         end
         OP_YEAR: begin
            yy_ff <= yy_in;
            qy_ff <= q100;
         end
         OP_CHECK: begin
            qyy_ff <= q100;
            if (cmd.sel_end) begin
               ok_e_ff <= date_ok;
            end else begin
               ok_s_ff <= date_ok;
            end
         end
         OP_DNUM: begin
            if (cmd.sel_end) begin
               ne_ff <= dnum;
            end else begin
               ns_ff <= dnum;
            end
         end
         OP_DIFF: begin
            total_ff <= ne_ff - ns_ff;
         end
         OP_DIV_W: begin
            q7_ff <= q7;
         end
         OP_REM_W: begin
            w_ff <= 3'(ns3 - q7_times7);
         end
         OP_DIV_T: begin
            q7_ff <= q7;
         end
         OP_FINISH: begin
            if (!(ok_s_ff && ok_e_ff)) begin
               count_ff  <= '0;
               status_ff <= STATUS_INVALID;
            end else if (ne_ff < ns_ff) begin
               count_ff  <= '0;
               status_ff <= STATUS_ORDER;
            end else begin
               count_ff  <= count_val;
               status_ff <= STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   assign business_days = count_ff;
   assign status        = status_ff;

endmodule

// ===== sv/business_day_counter.sv =====
// Counts Monday to Friday days from a start date, inclusive, up to an end
// date, exclusive, for Gregorian dates in years 1 to 9999. Both dates are
// turned into day numbers and the count is taken in closed form, so every
// word takes the same steps whatever the span: a request is taken when the
// block is idle, and the next request is taken only once the result word of
// the current one is written and the block is back in idle. The controller
// steps one shared divide-by-100 multiplier and one shared divide-by-7
// multiplier through the date checks, the two day numbers and the week
// split. A result waits in its output register while the next request is
// worked on; the next result is held back until the waiting word is taken.
// An invalid date gives status 2, an end before the start gives status 1,
// both with a count of 0.
module business_day_counter
   import bdc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   bdc_req_if.sink   req,
   bdc_rsp_if.source rsp
);

   cmd_type cmd;

   bdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .cmd       (cmd)
   );

   bdc_datapath u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .start_day     (req.start_day),
      .start_month   (req.start_month),
      .start_year    (req.start_year),
      .end_day       (req.end_day),
      .end_month     (req.end_month),
      .end_year      (req.end_year),
      .business_days (rsp.business_days),
      .status        (rsp.status)
   );

`ifndef ASSERT_OFF
   // busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request taken while busy");

   // error words carry no count
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != STATUS_OK) |-> (rsp.business_days == '0))
      else $error("nonzero count on error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.status == STATUS_OK || rsp.status == STATUS_ORDER ||
                     rsp.status == STATUS_INVALID))
      else $error("undefined status code");

   // a new word appears only when the block goes back to idle
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> req.ready)
      else $error("result shown while still busy");
`endif

endmodule
